FILE: hdl/dcsg_pkg.sv
package dcsg_pkg;

   // field and datapath widths
   localparam int SampleW  = 24;
   localparam int LevelW   = 16;
   localparam int CoefW    = 16;
   localparam int A0W      = 17;
   localparam int YW       = 28;
   localparam int YSumW    = 30;
   localparam int ZW       = 32;
   localparam int MulAW    = 29;
   localparam int MulBW    = 33;
   localparam int ProdW    = 62;
   localparam int AccW     = 50;
   localparam int OutRndW  = 31;
   localparam int ReqDataW = 40;
   localparam int RspDataW = 24;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 16;

   // 0.995 in Q0.16, and the smoother pole after reset
   localparam logic [CoefW-1:0] DC_POLE    = 16'd65208;
   localparam logic [CoefW-1:0] POLE_RESET = 16'd65365;

   // register indexes
   localparam logic [CsrAddrW-1:0] CSR_ENABLE         = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_DC_BLOCK_ON    = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_SMOOTHING_POLE = 2'd2;

   // operand selects of the shared multiplier
   localparam logic [1:0] MUL_Y      = 2'd0;
   localparam logic [1:0] MUL_LEVEL  = 2'd1;
   localparam logic [1:0] MUL_SMOOTH = 2'd2;
   localparam logic [1:0] MUL_OUT    = 2'd3;

   typedef struct packed {
      logic [1:0] mul_sel;
      logic       mul_en;
      logic       load_in;
      logic       y_upd;
      logic       acc_ld;
      logic       z_upd;
      logic       out_ld;
   } dcsg_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } dcsg_status_type;

endpackage

FILE: hdl/dcsg_ctrl.sv
module dcsg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  dcsg_pkg::dcsg_status_type status,
   output dcsg_pkg::dcsg_cmd_type    cmd
);
   import dcsg_pkg::*;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_MUL_Y      = 3'd1;
   localparam logic [2:0] ST_MUL_LEVEL  = 3'd2;
   localparam logic [2:0] ST_MUL_SMOOTH = 3'd3;
   localparam logic [2:0] ST_SUM_Z      = 3'd4;
   localparam logic [2:0] ST_MUL_OUT    = 3'd5;
   localparam logic [2:0] ST_FINISH     = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // sequencer: at most one multiply per step, result beat loaded in the last step
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_Y;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL_Y;
            end
         end
         ST_MUL_Y: begin
            cmd.mul_sel = MUL_Y;
            cmd.mul_en  = 1'b1;
            state_in    = ST_MUL_LEVEL;
         end
         ST_MUL_LEVEL: begin
            cmd.mul_sel = MUL_LEVEL;
            cmd.mul_en  = 1'b1;
            cmd.y_upd   = 1'b1;
            state_in    = ST_MUL_SMOOTH;
         end
         ST_MUL_SMOOTH: begin
            cmd.mul_sel = MUL_SMOOTH;
            cmd.mul_en  = 1'b1;
            cmd.acc_ld  = 1'b1;
            state_in    = ST_SUM_Z;
         end
         ST_SUM_Z: begin
            cmd.z_upd = 1'b1;
            state_in  = ST_MUL_OUT;
         end
         ST_MUL_OUT: begin
            cmd.mul_sel = MUL_OUT;
            cmd.mul_en  = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // wait while the output register still holds an untaken beat
            if (!status.out_blocked) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/dcsg_datapath.sv
module dcsg_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [dcsg_pkg::CsrAddrW-1:0]        csr_addr,
   input  logic [dcsg_pkg::CsrDataW-1:0]        csr_wr_data,
   input  logic [dcsg_pkg::ReqDataW-1:0]        req_tdata,
   input  dcsg_pkg::dcsg_cmd_type               cmd,
   output dcsg_pkg::dcsg_status_type            status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dcsg_pkg::RspDataW-1:0]        rsp_tdata
);
   import dcsg_pkg::*;

   localparam logic signed [ProdW-1:0]   YRound   = ProdW'(64'sd32768);
   localparam logic signed [ProdW-1:0]   OutRound = ProdW'(64'sd1073741824);
   localparam logic [AccW-1:0]           ZRound   = AccW'(32768);
   localparam logic signed [YSumW-1:0]   YMax     = YSumW'(134217727);
   localparam logic signed [YSumW-1:0]   YMin     = -YSumW'(134217728);
   localparam logic signed [OutRndW-1:0] OutMax   = OutRndW'(8388607);
   localparam logic signed [OutRndW-1:0] OutMin   = -OutRndW'(8388608);

   // configuration registers
   logic             enable_ff, enable_in;
   logic             dc_on_ff, dc_on_in;
   logic [CoefW-1:0] pole_ff, pole_in;

   // filter state
   logic signed [SampleW-1:0] prev_input_ff, prev_input_in;
   logic signed [YW-1:0]      prev_blocked_ff, prev_blocked_in;
   logic [ZW-1:0]             z_ff, z_in;

   // item and working registers
   logic signed [SampleW-1:0] x_ff, x_in;
   logic [LevelW-1:0]         level_ff, level_in;
   logic signed [ProdW-1:0]   product_ff, product_in;
   logic [AccW-1:0]           acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]       rsp_data_ff, rsp_data_in;

   logic [A0W-1:0]            a0;
   logic signed [MulAW-1:0]   mul_a;
   logic signed [MulBW-1:0]   mul_b;
   logic signed [YW-1:0]      v_sel;
   logic signed [ProdW-1:0]   y_rnd;
   logic signed [YSumW-1:0]   y_sum;
   logic signed [YW-1:0]      y_sat;
   logic signed [ProdW-1:0]   out_rnd;
   logic signed [OutRndW-1:0] out_q;
   logic [RspDataW-1:0]       out_sat;
   logic [AccW-1:0]           z_sum;

   // configuration writes; indexes past the list are ignored
   always_comb begin
      enable_in = enable_ff;
      dc_on_in  = dc_on_ff;
      pole_in   = pole_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_ENABLE:         enable_in = csr_wr_data[0];
            CSR_DC_BLOCK_ON:    dc_on_in  = csr_wr_data[0];
            CSR_SMOOTHING_POLE: pole_in   = csr_wr_data;
            default:            enable_in = enable_ff;
         endcase
      end
   end

   // shared multiplier operands
   assign a0    = A0W'(17'h10000) - {1'b0, pole_ff};
   assign v_sel = dc_on_ff ? prev_blocked_ff : YW'(x_ff);

   always_comb begin
      case (cmd.mul_sel)
         MUL_Y: begin
            mul_a = MulAW'(prev_blocked_ff);
            mul_b = {{(MulBW-CoefW){1'b0}}, DC_POLE};
         end
         MUL_LEVEL: begin
            mul_a = {{(MulAW-A0W){1'b0}}, a0};
            mul_b = {{(MulBW-LevelW){1'b0}}, level_ff};
         end
         MUL_SMOOTH: begin
            mul_a = {{(MulAW-CoefW){1'b0}}, pole_ff};
            mul_b = {1'b0, z_ff};
         end
         default: begin
            mul_a = MulAW'(v_sel);
            mul_b = {1'b0, z_ff};
         end
      endcase
   end

   assign product_in = cmd.mul_en ? mul_a * mul_b : product_ff;

   // DC blocker: y = x - x_prev + round(0.995 * y_prev), saturated to 28 bits
   assign y_rnd = product_ff + YRound;
   assign y_sum = YSumW'(x_ff) - YSumW'(prev_input_ff) + y_rnd[16 +: YSumW];

   always_comb begin
      if (y_sum > YMax) begin
         y_sat = YMax[YW-1:0];
      end else if (y_sum < YMin) begin
         y_sat = YMin[YW-1:0];
      end else begin
         y_sat = y_sum[YW-1:0];
      end
   end

   assign prev_blocked_in = cmd.y_upd ? y_sat : prev_blocked_ff;
   assign prev_input_in   = cmd.y_upd ? x_ff : prev_input_ff;

   // level smoother: acc holds level*a0 scaled up plus the rounding half
   assign acc_in = cmd.acc_ld ?
                   {product_ff[ZW:0], {CoefW{1'b0}}} + ZRound : acc_ff;
   assign z_sum  = acc_ff + AccW'(product_ff[ZW+CoefW-1:0]);
   assign z_in   = cmd.z_upd ? z_sum[CoefW +: ZW] : z_ff;

   // item capture
   assign x_in     = cmd.load_in ? req_tdata[SampleW-1:0] : x_ff;
   assign level_in = cmd.load_in ? req_tdata[SampleW +: LevelW] : level_ff;

   // output scaling: round(v * z / 2^31), saturated to 24 bits
   assign out_rnd = product_ff + OutRound;
   assign out_q   = out_rnd[31 +: OutRndW];

   always_comb begin
      if (out_q > OutMax) begin
         out_sat = OutMax[RspDataW-1:0];
      end else if (out_q < OutMin) begin
         out_sat = OutMin[RspDataW-1:0];
      end else begin
         out_sat = out_q[RspDataW-1:0];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = enable_ff ? out_sat : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.out_blocked = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_tdata          = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b1;
         dc_on_ff        <= 1'b1;
         pole_ff         <= POLE_RESET;
         prev_input_ff   <= '0;
         prev_blocked_ff <= '0;
         z_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         enable_ff       <= enable_in;
         dc_on_ff        <= dc_on_in;
         pole_ff         <= pole_in;
         prev_input_ff   <= prev_input_in;
         prev_blocked_ff <= prev_blocked_in;
         z_ff            <= z_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      level_ff    <= level_in;
      product_ff  <= product_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hdl/dc_block_smoothed_gain.sv
// Channel   Direction  Beat fields (lowest bit first)
// req_      in         tdata: sample_in[23:0], level_target[39:24]
// rsp_      out        tdata: sample_out[23:0]
// csr_      in         wr_en, addr (0 enable, 1 dc_block_on, 2 smoothing_pole), wr_data
//
// Each item runs from acceptance to the result beat through an accept step,
// four multiplies on the single shared 29x33 multiplier, one add for the
// smoothed level and a step to round, saturate and load the output register.
// A new item is taken once the previous one has moved into the output register.
// A stalled result beat holds the last step; reset is synchronous and restores
// the register defaults and clears the filter state.
module dc_block_smoothed_gain (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dcsg_pkg::ReqDataW-1:0]     req_tdata,  // sample_in, level_target
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dcsg_pkg::RspDataW-1:0]     rsp_tdata,  // sample_out
   input  logic                              csr_wr_en,
   input  logic [dcsg_pkg::CsrAddrW-1:0]     csr_addr,
   input  logic [dcsg_pkg::CsrDataW-1:0]     csr_wr_data
);
   import dcsg_pkg::*;

   dcsg_cmd_type    cmd;
   dcsg_status_type status;

   dcsg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dcsg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // an accepted beat starts the sequence, so the input closes next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after accepting a beat");

   // state updates happen in distinct steps of the sequence
   a_steps_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_in, cmd.y_upd, cmd.acc_ld, cmd.z_upd, cmd.out_ld}))
      else $error("overlapping sequencer steps");

   // a result beat only appears after the final step loaded it
   a_result_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_ld))
      else $error("result beat without a load");

   // never load over a beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> !(rsp_tvalid && !rsp_tready))
      else $error("result beat overwritten");

endmodule

FILE: test/dc_block_smoothed_gain_tb.sv
module dc_block_smoothed_gain_tb;
   import dcsg_pkg::*;

   localparam int CycleLimit = 400000;
   localparam longint SampleMax = 64'sd8388607;
   localparam longint SampleMin = -64'sd8388608;
   localparam longint BlockedMax = 64'sd134217727;
   localparam longint BlockedMin = -64'sd134217728;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;   // sample_in[23:0], level_target[39:24]
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;   // sample_out[23:0]
   logic                csr_wr_en;
   logic [CsrAddrW-1:0] csr_addr;
   logic [CsrDataW-1:0] csr_wr_data;

   // register copies held by the predictor
   logic             cfg_enable;
   logic             cfg_dc_block_on;
   logic [CoefW-1:0] cfg_pole;

   // filter state held by the predictor
   logic signed [SampleW-1:0] dcb_last_in;
   logic signed [YW-1:0]      dcb_last_y;
   logic [ZW-1:0]             level_smooth;

   logic [RspDataW-1:0] out_samples_due[$];
   logic [RspDataW-1:0] due_sample;

   int  mismatches;
   int  beats_sent;
   int  beats_checked;
   int  settings_used;
   int  cycle_count;
   int  hold_len;
   bit  req_burst;
   bit  rsp_burst;

   dc_block_smoothed_gain uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
         $display("** dc_block_smoothed_gain: FAILED **");
         $finish;
      end
   end

   // one step of DC blocker, level smoother and gain; updates the state copies
   function automatic logic [RspDataW-1:0] gain_stage_step(input logic [SampleW-1:0] smp,
                                                             input logic [LevelW-1:0] lvl);
      longint x;
      longint y;
      longint v;
      longint o;
      longint zs;
      longint unsigned lv;
      longint unsigned b1;
      longint unsigned a0;
      longint unsigned acc;
      x = longint'($signed(smp));
      y = x - longint'(dcb_last_in)
          + ((longint'(dcb_last_y) * longint'(DC_POLE) + 64'sd32768) >>> 16);
      if (y > BlockedMax) y = BlockedMax;
      if (y < BlockedMin) y = BlockedMin;
      dcb_last_in = smp;
      dcb_last_y  = y[YW-1:0];
      // smoother: a0 = 1 - b1 in Q0.16
      lv  = {48'd0, lvl};
      b1  = {48'd0, cfg_pole};
      a0  = 64'd65536 - b1;
      acc = (lv << 16) * a0 + {32'd0, level_smooth} * b1 + 64'd32768;
      level_smooth = acc[47:16];
      if (!cfg_enable) begin
         o = 0;
      end else begin
         v  = cfg_dc_block_on ? y : x;
         zs = longint'({32'd0, level_smooth});
         o  = (v * zs + (longint'(1) <<< 30)) >>> 31;
         if (o > SampleMax) o = SampleMax;
         if (o < SampleMin) o = SampleMin;
      end
      return o[RspDataW-1:0];
   endfunction

   // offer one beat after a random gap, or at once in burst mode; predict once it is taken
   task automatic send_item(input logic [SampleW-1:0] smp, input logic [LevelW-1:0] lvl);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {lvl, smp};
      do @(posedge clock); while (!req_tready);
      out_samples_due.push_back(gain_stage_step(smp, lvl));
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (out_samples_due.size() != 0) @(posedge clock);
   endtask

   // all three registers in consecutive cycles, only with the block idle
   task automatic set_config(input logic en, input logic dcb, input logic [CoefW-1:0] pole);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_addr    <= CSR_ENABLE;
      csr_wr_data <= {{(CsrDataW-1){1'b0}}, en};
      @(posedge clock);
      csr_addr    <= CSR_DC_BLOCK_ON;
      csr_wr_data <= {{(CsrDataW-1){1'b0}}, dcb};
      @(posedge clock);
      csr_addr    <= CSR_SMOOTHING_POLE;
      csr_wr_data <= pole;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_enable      = en;
      cfg_dc_block_on = dcb;
      cfg_pole        = pole;
      settings_used++;
   endtask

   function automatic logic [SampleW-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0:       return SampleMax[SampleW-1:0];
         1:       return SampleMin[SampleW-1:0];
         2:       return SampleW'($urandom_range(0, 2047));
         3:       return -SampleW'($urandom_range(0, 2047));
         default: return SampleW'($urandom);
      endcase
   endfunction

   function automatic logic [LevelW-1:0] draw_level();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return 16'd32768;
         default: return LevelW'($urandom);
      endcase
   endfunction

   // reset values of the registers, extremes of both fields
   task automatic test_defaults();
      send_item(24'sd0, 16'd32768);
      send_item(SampleMax[SampleW-1:0], 16'd65535);
      send_item(SampleMin[SampleW-1:0], 16'd65535);
      send_item(-24'sd1, 16'd0);
      send_item(24'sd1, 16'd32768);
      send_item(24'sd0, 16'd0);
   endtask

   // zero pole: level taken at once; gain near two saturates the output,
   // alternating full-scale steps feed the blocker its largest input swings
   task automatic test_pole_zero();
      set_config(1'b1, 1'b1, '0);
      send_item(SampleMax[SampleW-1:0], 16'd65535);
      for (int i = 0; i < 8; i++)
         send_item(i[0] ? SampleMax[SampleW-1:0] : SampleMin[SampleW-1:0], 16'd65535);
      send_item(24'sd0, 16'd0);
   endtask

   // disabled block still runs its filters; then the raw path
   task automatic test_disabled_and_raw();
      set_config(1'b0, 1'b1, POLE_RESET);
      send_item(SampleMax[SampleW-1:0], 16'd65535);
      send_item(SampleMin[SampleW-1:0], 16'd12345);
      send_item(24'sd777, 16'd32768);
      set_config(1'b1, 1'b0, '0);
      send_item(SampleMax[SampleW-1:0], 16'd65535);
      send_item(SampleMin[SampleW-1:0], 16'd65535);
      set_config(1'b1, 1'b0, '1);
      send_item(24'sd12345, 16'd32768);
   endtask

   // random content over a series of settings, with and without idling
   task automatic test_random_phases();
      logic [CoefW-1:0] pole;
      for (int p = 0; p < 13; p++) begin
         case (p % 6)
            0:       pole = POLE_RESET;
            1:       pole = '0;
            2:       pole = '1;
            3:       pole = CoefW'($urandom);
            4:       pole = CoefW'($urandom_range(60000, 65535));
            default: pole = CoefW'($urandom_range(0, 4095));
         endcase
         set_config($urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)), pole);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < 70; i++)
            send_item(draw_sample(), draw_level());
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;
   endtask

   // receiver holds off for a long stretch while beats keep coming
   task automatic test_output_stall();
      set_config(1'b1, 1'b1, POLE_RESET);
      hold_len  = 250;
      req_burst = 1'b1;
      for (int i = 0; i < 30; i++)
         send_item(draw_sample(), draw_level());
      req_burst = 1'b0;
   endtask

   // result side: random stall per beat, or a requested long hold
   initial begin : rsp_side
      int w;
      forever begin
         if (hold_len > 0) begin
            w        = hold_len;
            hold_len = 0;
         end else begin
            w = rsp_burst ? 0 : $urandom_range(0, 11);
         end
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (out_samples_due.size() == 0) begin
            mismatches++;
            $display("%0t: sample_out expected none, actual %0d", $time, $signed(rsp_tdata));
         end else begin
            due_sample = out_samples_due.pop_front();
            if (rsp_tdata !== due_sample) begin
               mismatches++;
               $display("%0t: sample_out expected %0d, actual %0d", $time,
                        $signed(due_sample), $signed(rsp_tdata));
            end
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_addr    <= CSR_ENABLE;
      csr_wr_data <= '0;
      cycle_count = 0;
      mismatches = 0;
      beats_sent = 0;
      beats_checked = 0;
      settings_used = 0;
      hold_len = 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      cfg_enable = 1'b1;
      cfg_dc_block_on = 1'b1;
      cfg_pole = POLE_RESET;
      dcb_last_in = '0;
      dcb_last_y = '0;
      level_smooth = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_pole_zero();
      test_disabled_and_raw();
      test_random_phases();
      test_output_stall();

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Run covered %0d input beats and %0d result beats over %0d register settings,",
               beats_sent, beats_checked, settings_used);
      $display("including zero and full-scale poles, bypass, disable and a long output stall.");
      if (mismatches == 0 && out_samples_due.size() == 0)
         $display("** dc_block_smoothed_gain: PASSED **");
      else
         $display("** dc_block_smoothed_gain: FAILED **");
      $finish;
   end

endmodule
